// File: hw/rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg: shared definitions for greedy box suppression
// Field widths, the default store depth and the reset overlap threshold used by the block and its channels.
// ----------------------------------------------------------------------------
package gbs_pkg;

	localparam int MAX_BOXES_DEF = 64;
	localparam int COORD_W       = 16;
	localparam int SCORE_W       = 16;
	localparam int INDEX_W       = 6;
	localparam int BOX_W         = 4 * COORD_W;
	localparam logic [SCORE_W-1:0] IOU_RESET = 16'd29491;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [SCORE_W-1:0] score_t;
	typedef logic [INDEX_W-1:0] index_t;

endpackage

// File: hw/rtl/gbs_box_if.sv
// ----------------------------------------------------------------------------
// gbs_box_if: input box channel
// Valid/ready channel carrying one box and its class score.
// ----------------------------------------------------------------------------
interface gbs_box_if import gbs_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t box_x;
	coord_t box_y;
	coord_t box_w;
	coord_t box_h;
	score_t class_score;
	logic   last_box;

	modport source (output valid, box_x, box_y, box_w, box_h, class_score, last_box,
		input ready);
	modport sink (input valid, box_x, box_y, box_w, box_h, class_score, last_box,
		output ready);
endinterface

// File: hw/rtl/gbs_res_if.sv
// ----------------------------------------------------------------------------
// gbs_res_if: result channel
// Valid/ready channel carrying one suppression result per loaded box.
// ----------------------------------------------------------------------------
interface gbs_res_if import gbs_pkg::*; ();
	logic   valid;
	logic   ready;
	index_t box_index;
	score_t kept_score;
	logic   last_result;

	modport source (output valid, box_index, kept_score, last_result, input ready);
	modport sink (input valid, box_index, kept_score, last_result, output ready);
endinterface

// File: hw/rtl/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression: greedy IoU non-maximum suppression for one class
// Loads a set of boxes, suppresses overlaps in score order, emits the scores.
// ----------------------------------------------------------------------------
// Boxes are taken one transaction per cycle while the block is loading; the
// transaction with last_box set closes the set (a set that already holds
// MAX_BOXES boxes drops further boxes). The suppression pass then handles the
// surviving boxes in descending score order (ties in load order). For each such
// box a scan (n = boxes in the set) pushes every stored box through
// one shared five-stage overlap pipeline: overlap, area multiply, union,
// threshold multiply and compare. Each scan starts by reading the leading box
// and ends by draining the pipeline; the pass runs one scan for each box that
// survives with a nonzero score; boxes that are suppressed or have a zero
// score cost no scan. The same scan also finds the next leading box, so no
// separate sort is needed. Results then leave in load order, each read out
// only after the one before has been taken, and the block takes no new box
// until the last result has been taken.
// ----------------------------------------------------------------------------
module greedy_box_suppression import gbs_pkg::*; #(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	gbs_box_if.sink        boxes,
	gbs_res_if.source      results,
	input  logic           cfg_write_en,
	input  logic [SCORE_W-1:0] cfg_write_data
);
	localparam int AW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	typedef enum logic [8:0] {
		ST_LOAD   = 9'b000000001,
		ST_SETUP  = 9'b000000010,
		ST_LATCH  = 9'b000000100,
		ST_AREA   = 9'b000001000,
		ST_SCAN   = 9'b000010000,
		ST_DRAIN  = 9'b000100000,
		ST_OUT_RD = 9'b001000000,
		ST_OUT_LD = 9'b010000000,
		ST_OUT_SH = 9'b100000000
	} state_t;

	// Overlap of [a0,a1] with [b0,b1] on 17-bit edges.
	function automatic logic [16:0] overlap(input logic [16:0] a0, input logic [16:0] a1,
		input logic [16:0] b0, input logic [16:0] b1);
		logic [16:0] hi;
		hi = (a1 < b1) ? a1 : b1;
		if (b0 < a0) begin
			overlap = (b1 < a0) ? 17'd0 : hi - a0;
		end else begin
			overlap = (a1 < b0) ? 17'd0 : hi - b0;
		end
	endfunction

	state_t state_q;
	logic [SCORE_W-1:0] thr_q;
	logic [CW-1:0] count_q, n_q, j_q, k_q;
	logic [AW-1:0] a_q, best_i_q;
	logic [SCORE_W-1:0] a_s_q, best_s_q;
	logic best_v_q;
	coord_t ax_q, ay_q, aw_q, ah_q;
	logic [31:0] area_a_q;

	// Memories.
	logic box_we, score_we;
	logic [AW-1:0] waddr, raddr, score_waddr;
	logic [BOX_W-1:0] box_wdata, box_rdata;
	score_t score_wdata, score_rdata;

	gbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
		.clk(clk), .we(box_we), .waddr(waddr), .wdata(box_wdata),
		.raddr(raddr), .rdata(box_rdata));

	gbs_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
		.clk(clk), .we(score_we), .waddr(score_waddr), .wdata(score_wdata),
		.raddr(raddr), .rdata(score_rdata));

	// Load side.
	logic in_acc, full, take, ld_better;
	logic [CW-1:0] count_nxt;
	assign boxes.ready = (state_q == ST_LOAD);
	assign in_acc     = boxes.valid && boxes.ready;
	assign full       = (count_q == CW'(MAX_BOXES));
	assign take       = in_acc && !full;
	assign count_nxt  = count_q + CW'(!full);
	assign waddr      = count_q[AW-1:0];
	assign box_we     = take;
	assign box_wdata  = {boxes.box_h, boxes.box_w, boxes.box_y, boxes.box_x};
	// The leading box is tracked while loading, so the pass starts at once.
	assign ld_better  = take && (boxes.class_score != '0) &&
		(!best_v_q || boxes.class_score > best_s_q);

	// Pipeline registers of the shared overlap unit.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0] j_s1, j_s2, j_s3, j_s4, j_s5;
	score_t s_s2, s_s3, s_s4, s_s5;
	logic [16:0] iw_s2, ih_s2;
	coord_t bw_s2, bh_s2;
	logic [33:0] inter_s3, inter_s4, inter_s5;
	logic [31:0] areab_s3;
	logic [32:0] uni_s4;
	logic nz_s4, nz_s5;
	logic [48:0] prod_s5;

	// Stage 1 combinational overlap of the leading box with the box read out.
	logic [16:0] bx17, by17;
	assign bx17 = {1'b0, box_rdata[15:0]};
	assign by17 = {1'b0, box_rdata[31:16]};

	logic [32:0] areas_s3;
	assign areas_s3 = {1'b0, area_a_q} + {1'b0, areab_s3};

	// Stage 5: the decision.
	logic sup, after_a, kill, better;
	assign sup     = nz_s5 && ({inter_s5, 16'd0} >= {1'b0, prod_s5});
	assign after_a = (s_s5 < a_s_q) || ((s_s5 == a_s_q) && (j_s5 > a_q));
	assign kill    = v_s5 && after_a && (s_s5 != '0) && sup;
	assign better  = v_s5 && after_a && (s_s5 != '0) && !sup &&
		(!best_v_q || s_s5 > best_s_q);

	assign score_we    = take || kill;
	assign score_waddr = take ? count_q[AW-1:0] : j_s5;
	assign score_wdata = take ? boxes.class_score : '0;

	logic pipe_busy;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;

	always_comb begin
		unique case (state_q)
			ST_SETUP:  raddr = a_q;
			ST_SCAN:   raddr = j_q[AW-1:0];
			ST_OUT_RD: raddr = k_q[AW-1:0];
			default:   raddr = a_q;
		endcase
	end

	// Result register.
	logic res_v_q, res_last_q;
	index_t res_idx_q;
	score_t res_score_q;
	logic out_acc;
	assign results.valid       = res_v_q;
	assign results.box_index   = res_idx_q;
	assign results.kept_score  = res_score_q;
	assign results.last_result = res_last_q;
	assign out_acc = res_v_q && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= IOU_RESET;
		end else if (cfg_write_en) begin
			thr_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			best_v_q <= 1'b0;
			j_q      <= '0;
			k_q      <= '0;
			res_v_q  <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (better) begin
				best_v_q <= 1'b1;
				best_s_q <= s_s5;
				best_i_q <= j_s5;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (ld_better) begin
						best_v_q <= 1'b1;
						best_s_q <= boxes.class_score;
						best_i_q <= count_q[AW-1:0];
					end
					if (in_acc) begin
						if (boxes.last_box) begin
							count_q <= '0;
							n_q     <= count_nxt;
							k_q     <= '0;
							if (ld_better || best_v_q) begin
								a_q   <= ld_better ? count_q[AW-1:0] : best_i_q;
								a_s_q <= ld_better ? boxes.class_score : best_s_q;
								state_q <= ST_SETUP;
							end else begin
								state_q <= ST_OUT_RD;
							end
						end else begin
							count_q <= count_nxt;
						end
					end
				end
				ST_SETUP: state_q <= ST_LATCH;
				ST_LATCH: begin
					ax_q <= box_rdata[15:0];
					ay_q <= box_rdata[31:16];
					aw_q <= box_rdata[47:32];
					ah_q <= box_rdata[63:48];
					state_q <= ST_AREA;
				end
				ST_AREA: begin
					area_a_q <= aw_q * ah_q;
					best_v_q <= 1'b0;
					j_q      <= '0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					j_q <= j_q + 1'b1;
					if (j_q + 1'b1 == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						best_v_q <= 1'b0;
						if (best_v_q) begin
							a_q     <= best_i_q;
							a_s_q   <= best_s_q;
							state_q <= ST_SETUP;
						end else begin
							state_q <= ST_OUT_RD;
						end
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_LD;
				ST_OUT_LD: begin
					res_v_q     <= 1'b1;
					res_idx_q   <= INDEX_W'(k_q);
					res_score_q <= score_rdata;
					res_last_q  <= (k_q + 1'b1 == n_q);
					state_q     <= ST_OUT_SH;
				end
				ST_OUT_SH: begin
					if (out_acc) begin
						res_v_q <= 1'b0;
						k_q     <= k_q + 1'b1;
						state_q <= res_last_q ? ST_LOAD : ST_OUT_RD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Datapath of the shared overlap unit; no reset needed.
	always_ff @(posedge clk) begin
		j_s1 <= j_q[AW-1:0];
		// Stage 1: edge overlaps.
		j_s2  <= j_s1;
		s_s2  <= score_rdata;
		iw_s2 <= overlap({1'b0, ax_q}, {1'b0, ax_q} + 17'(aw_q),
			bx17, bx17 + 17'(box_rdata[47:32]));
		ih_s2 <= overlap({1'b0, ay_q}, {1'b0, ay_q} + 17'(ah_q),
			by17, by17 + 17'(box_rdata[63:48]));
		bw_s2 <= box_rdata[47:32];
		bh_s2 <= box_rdata[63:48];
		// Stage 2: intersection and area of the other box.
		j_s3     <= j_s2;
		s_s3     <= s_s2;
		inter_s3 <= iw_s2 * ih_s2;
		areab_s3 <= bw_s2 * bh_s2;
		// Stage 3: union; a zero union never suppresses.
		j_s4     <= j_s3;
		s_s4     <= s_s3;
		inter_s4 <= inter_s3;
		nz_s4    <= {2'b0, areas_s3} > {1'b0, inter_s3};
		uni_s4   <= 33'({2'b0, areas_s3} - {1'b0, inter_s3});
		// Stage 4: threshold times union.
		j_s5     <= j_s4;
		s_s5     <= s_s4;
		inter_s5 <= inter_s4;
		nz_s5    <= nz_s4;
		prod_s5  <= thr_q * uni_s4;
	end

endmodule

// File: hw/rtl/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker: port-level checks for greedy box suppression
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module gbs_checker import gbs_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input index_t out_index,
	input score_t out_score,
	input logic   out_last
);
	// The block never loads boxes while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("load and emit overlap");

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index) &&
		$stable(out_score) && $stable(out_last)) else $error("stalled result changed");

	// After the final result the block returns to loading.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> in_ready && !out_valid)
		else $error("block did not return to loading");

	// Between results of one run no box is taken.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !in_ready)
		else $error("box taken inside a run");
endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(boxes.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_index(results.box_index),
	.out_score(results.kept_score),
	.out_last(results.last_result)
);
